FILE: src/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants
// Word layouts, status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int BLOCKS        = 1024;
  localparam int ID_W          = 10;   // block index width
  localparam int ROW_BITS      = 32;   // bitmap bits per memory row
  localparam int ROW_W         = 5;    // bitmap row address width
  localparam int ROWS          = BLOCKS / ROW_BITS;
  localparam int LEN_W         = 16;
  localparam int CNT_W         = 11;   // free count, 0..BLOCKS
  localparam int NEED_W        = 8;    // blocks per chain, at most 132
  localparam int PAYLOAD       = 500;
  // floor(y / 125) == (y * RECIP) >> RSHIFT for every y below 21499.
  localparam int RECIP         = 16778;
  localparam int RSHIFT        = 21;
  localparam int PROD_W        = 30;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_BADID = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] byte_length;
    logic [10:0] chain_id;
  } in_word_t;

  typedef struct packed {
    logic [10:0] head_id;
    logic [1:0]  status;
    logic [10:0] free_blocks;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_MUL, S_NEED,
    S_ARD, S_AWAIT, S_APICK, S_AWB, S_ALINK,
    S_FRD, S_FWAIT, S_FCHK, S_FCLR, S_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       clr;
    logic       mul;
    logic       need;
    logic       ard;
    logic       await_row;
    logic       apick;
    logic       awb;
    logic       alink;
    logic       frd;
    logic       fwait;
    logic       fclr;
    logic       res_load;
    logic       st_en;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic len_zero;
    logic id_bad;
    logic full;
    logic has_free;
    logic last_pick;
    logic alloc_done;
    logic bit_set;
    logic first;
    logic free_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/chained_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_block_allocator: bitmap block allocator with chained blocks
// Allocates and frees chains of 500-byte blocks from a pool of 1024.
// ----------------------------------------------------------------------------
//
//   channel   handshake            word           direction
//   in_       in_valid / in_stall  in_word_t      request into the block
//   out_      out_valid/out_stall  out_word_t     one result per request
//
// After reset a clearing pass zeroes the usage bitmap one 32-bit row per
// cycle, during which in_stall stays high.
// Requests are handled one at a time. An allocation is bounded by the
// bitmap row scan; a free is bounded by the memory read per link.
// The result sits in an output register; a new request is accepted while
// it waits, and the next result is held back until that register empties.
//
module chained_block_allocator import cba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each request; the datapath holds all storage.
  cba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  cba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // The free count can never rise above the pool size.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.free_blocks <= 11'(BLOCKS))
    else $error("free count above pool size");

  // Only a successful allocation reports a head block.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.head_id != '0 |-> out_word.status == ST_OK)
    else $error("head id on a failed request");

  // An accepted request keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

endmodule

FILE: src/cba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/cba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ctrl: request sequencer
// Steps through the clearing pass, allocation scan and free walk.
// ----------------------------------------------------------------------------
module cba_ctrl import cba_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        if (stat.kind == KIND_ALLOC) begin
          state_nxt = stat.len_zero ? S_DONE : S_MUL;
        end else begin
          state_nxt = stat.id_bad ? S_DONE : S_FRD;
        end
      end
      S_MUL:   state_nxt = S_NEED;
      S_NEED: begin
        if (stat.kind == KIND_ALLOC) begin
          state_nxt = stat.full ? S_DONE : S_ARD;
        end else begin
          state_nxt = S_FCLR;
        end
      end
      S_ARD:   state_nxt = S_AWAIT;
      S_AWAIT: state_nxt = S_APICK;
      S_APICK: if (!stat.has_free || stat.last_pick) state_nxt = S_AWB;
      S_AWB:   state_nxt = stat.alloc_done ? S_ALINK : S_ARD;
      S_ALINK: state_nxt = S_DONE;
      S_FRD:   state_nxt = S_FWAIT;
      S_FWAIT: state_nxt = S_FCHK;
      S_FCHK: begin
        if (!stat.bit_set) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = stat.first ? S_MUL : S_FCLR;
        end
      end
      S_FCLR:  state_nxt = stat.free_last ? S_DONE : S_FRD;
      S_DONE:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_DEC: begin
        if (stat.kind == KIND_ALLOC && stat.len_zero) begin
          cmd.st_en = 1'b1;
          cmd.st    = ST_ZERO;
        end else if (stat.kind != KIND_ALLOC && stat.id_bad) begin
          cmd.st_en = 1'b1;
          cmd.st    = ST_BADID;
        end
      end
      S_MUL: cmd.mul = 1'b1;
      S_NEED: begin
        cmd.need = 1'b1;
        if (stat.kind == KIND_ALLOC && stat.full) begin
          cmd.st_en = 1'b1;
          cmd.st    = ST_FULL;
        end
      end
      S_ARD:   cmd.ard = 1'b1;
      S_AWAIT: cmd.await_row = 1'b1;
      S_APICK: cmd.apick = 1'b1;
      S_AWB:   cmd.awb = 1'b1;
      S_ALINK: cmd.alink = 1'b1;
      S_FRD:   cmd.frd = 1'b1;
      S_FWAIT: cmd.fwait = 1'b1;
      S_FCHK: begin
        if (!stat.bit_set && stat.first) begin
          cmd.st_en = 1'b1;
          cmd.st    = ST_BADID;
        end
      end
      S_FCLR:  cmd.fclr = 1'b1;
      S_DONE:  cmd.res_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/cba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_dp: allocator datapath
// Bitmap, link and length memories, block count unit and result register.
// ----------------------------------------------------------------------------
module cba_dp import cba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic                kind_r;
  logic [LEN_W-1:0]    len_r;
  logic [10:0]         id_r;
  logic [ID_W-1:0]     cur_r;
  logic [PROD_W-1:0]   prod_r;
  logic [NEED_W-1:0]   need_r;
  logic [CNT_W-1:0]    fc_r;
  logic [ROW_W-1:0]    row_r;
  logic [ROW_W-1:0]    clr_row_r;
  logic [ROW_BITS-1:0] word_r;
  logic [ID_W-1:0]     link_r;
  logic [NEED_W-1:0]   taken_r;
  logic [NEED_W-1:0]   cnt_r;
  logic [ID_W-1:0]     prev_r;
  logic [ID_W-1:0]     head_r;
  logic                head_ok_r;
  logic [LEN_W-1:0]    remain_r;
  logic                first_r;
  logic [1:0]          st_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic [ROW_BITS-1:0] bm_q;
  logic [ID_W-1:0]     lk_q;
  logic [LEN_W-1:0]    by_q;
  logic                bm_we, bm_re, lk_we, by_we, fr_re;
  logic [ROW_W-1:0]    bm_waddr, bm_raddr;
  logic [ROW_BITS-1:0] bm_wdata;
  logic [ID_W-1:0]     lk_waddr, lk_wdata;

  logic [16:0]         len_ext;
  logic [14:0]         quarter;
  logic [NEED_W:0]     need_raw;
  logic [NEED_W-1:0]   need_nxt;
  logic [4:0]          pick_pos;
  logic [ID_W-1:0]     pick_idx;
  logic [ROW_BITS-1:0] cur_mask;

  // Lowest clear bit of the current bitmap row.
  always_comb begin
    pick_pos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!word_r[i]) begin
        pick_pos = 5'(i);
      end
    end
  end

  assign pick_idx = {row_r, pick_pos};
  assign cur_mask = ROW_BITS'(1) << cur_r[4:0];
  assign len_ext  = {1'b0, len_r} + 17'(PAYLOAD - 1);
  assign quarter  = len_ext[16:2];
  assign need_raw = prod_r[RSHIFT +: NEED_W + 1];
  // Block count of the current length, valid while the product is held.
  assign need_nxt = (need_raw == '0) ? NEED_W'(1) : need_raw[NEED_W-1:0];

  assign bm_we    = cmd.clr || cmd.awb || cmd.fclr;
  assign bm_waddr = cmd.clr ? clr_row_r : (cmd.awb ? row_r : cur_r[ID_W-1:ROW_W]);
  assign bm_wdata = cmd.clr ? '0 : (cmd.awb ? word_r : (word_r & ~cur_mask));
  assign bm_re    = cmd.ard || cmd.frd;
  assign bm_raddr = cmd.ard ? row_r : cur_r[ID_W-1:ROW_W];
  assign fr_re    = cmd.frd;

  assign lk_we    = cmd.alink || (cmd.apick && word_r != '1 && taken_r != '0);
  assign lk_waddr = prev_r;
  assign lk_wdata = cmd.alink ? prev_r : pick_idx;
  assign by_we    = cmd.apick && word_r != '1;

  cba_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_q)
  );

  cba_ram #(.WIDTH(ID_W), .DEPTH(BLOCKS)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .re(fr_re), .raddr(cur_r), .rdata(lk_q)
  );

  cba_ram #(.WIDTH(LEN_W), .DEPTH(BLOCKS)) u_bytes (
    .clk(clk), .we(by_we), .waddr(pick_idx), .wdata(remain_r),
    .re(fr_re), .raddr(cur_r), .rdata(by_q)
  );

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= CNT_W'(BLOCKS);
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_row_r <= clr_row_r + 1'b1;
      end
      if (cmd.alink) begin
        fc_r <= fc_r - {3'b0, taken_r};
      end else if (cmd.fclr) begin
        fc_r <= fc_r + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_word.kind;
      len_r     <= in_word.byte_length;
      id_r      <= in_word.chain_id;
      cur_r     <= ID_W'(in_word.chain_id - 11'd1);
      first_r   <= 1'b1;
      cnt_r     <= '0;
      taken_r   <= '0;
      row_r     <= '0;
      head_ok_r <= 1'b0;
      st_r      <= ST_OK;
      remain_r  <= in_word.byte_length;
    end
    if (cmd.st_en) begin
      st_r <= cmd.st;
    end
    if (cmd.mul) begin
      prod_r <= {15'b0, quarter} * PROD_W'(RECIP);
    end
    if (cmd.need) begin
      need_r <= need_nxt;
    end
    if (cmd.await_row) begin
      word_r <= bm_q;
    end
    if (cmd.apick && word_r != '1) begin
      word_r[pick_pos] <= 1'b1;
      prev_r           <= pick_idx;
      taken_r          <= taken_r + 1'b1;
      remain_r         <= (remain_r > LEN_W'(PAYLOAD)) ? remain_r - LEN_W'(PAYLOAD) : '0;
      if (taken_r == '0) begin
        head_r <= pick_idx;
      end
    end
    if (cmd.awb && taken_r != need_r) begin
      row_r <= row_r + 1'b1;
    end
    if (cmd.alink) begin
      head_ok_r <= 1'b1;
    end
    if (cmd.fwait) begin
      word_r <= bm_q;
      link_r <= lk_q;
      if (first_r) begin
        len_r <= by_q;
      end
    end
    if (cmd.fclr) begin
      cur_r   <= link_r;
      cnt_r   <= cnt_r + 1'b1;
      first_r <= 1'b0;
    end
    if (cmd.res_load) begin
      out_word_r.head_id     <= head_ok_r ? {1'b0, head_r} + 11'd1 : '0;
      out_word_r.status      <= st_r;
      out_word_r.free_blocks <= fc_r;
    end
  end

  always_comb begin
    stat            = '0;
    stat.kind       = kind_r;
    stat.len_zero   = (len_r == '0);
    stat.id_bad     = (id_r == '0) || (id_r > 11'(BLOCKS));
    stat.full       = ({3'b0, need_nxt} > fc_r);
    stat.has_free   = (word_r != '1);
    stat.last_pick  = (taken_r + 1'b1 == need_r);
    stat.alloc_done = (taken_r == need_r);
    stat.bit_set    = word_r[cur_r[4:0]];
    stat.first      = first_r;
    stat.free_last  = (cnt_r + 1'b1 >= need_r);
    stat.clr_last   = (clr_row_r == ROW_W'(ROWS - 1));
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: tb/tb_chained_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_block_allocator: self-checking bench for the block allocator
// Drives allocate and free requests through the valid/stall input channel,
// predicts each result word from a behavioral model of the pool and compares
// it field by field with the words taken off the output channel.
// ----------------------------------------------------------------------------
module tb_chained_block_allocator;
  import cba_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  chained_block_allocator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pool model: usage bits, links and remaining byte counts per block.
  bit          pool_used [BLOCKS];
  int unsigned pool_next [BLOCKS];
  int unsigned pool_bytes[BLOCKS];
  int unsigned pool_free;

  out_word_t   result_queue[$];
  int          error_count;
  int          idle_cycles;
  // Percent chances that the sender idles or the receiver stalls.
  int unsigned send_gap_pct;
  int unsigned stall_pct;

  function automatic int unsigned blocks_needed(int unsigned len);
    return (len + PAYLOAD - 1) / PAYLOAD;
  endfunction

  // Applies one request to the pool model and returns the expected word.
  function automatic out_word_t pool_apply(in_word_t req);
    out_word_t   res;
    int unsigned need, taken, remain, prev, cur, n;
    res = '0;
    res.status = ST_OK;
    if (req.kind == KIND_ALLOC) begin
      need = blocks_needed(req.byte_length);
      if (req.byte_length == 0) begin
        res.status = ST_ZERO;
      end else if (need > pool_free) begin
        res.status = ST_FULL;
      end else begin
        taken  = 0;
        remain = req.byte_length;
        prev   = 0;
        for (int i = 0; i < BLOCKS && taken < need; i++) begin
          if (!pool_used[i]) begin
            pool_used[i]  = 1'b1;
            pool_bytes[i] = remain;
            pool_next[i]  = i;
            if (taken == 0) res.head_id = 11'(i + 1);
            else pool_next[prev] = i;
            remain = (remain > PAYLOAD) ? remain - PAYLOAD : 0;
            prev   = i;
            taken++;
          end
        end
        pool_free -= taken;
      end
    end else begin
      if (req.chain_id == 0 || req.chain_id > BLOCKS || !pool_used[req.chain_id - 1]) begin
        res.status = ST_BADID;
      end else begin
        cur = req.chain_id - 1;
        n   = blocks_needed(pool_bytes[cur]);
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
          if (!pool_used[cur]) break;
          pool_used[cur] = 1'b0;
          pool_free++;
          cur = pool_next[cur];
        end
      end
    end
    res.free_blocks = 11'(pool_free);
    return res;
  endfunction

  // Sends one word, predicting its result at the moment it is accepted.
  // Valid stays high after acceptance until the next call drives the
  // following word or an idle cycle in the same time step.
  task automatic send_request(input logic kind, input int unsigned len,
                              input int unsigned id);
    in_word_t req;
    req.kind        = kind;
    req.byte_length = 16'(len);
    req.chain_id    = 11'(id);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      in_word  <= in_word_t'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_queue.push_back(pool_apply(req));
  endtask

  // Receiver: random stall, then check every accepted result word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_word);
          error_count++;
        end else begin
          out_word_t exp_word;
          exp_word = result_queue.pop_front();
          if (out_word.head_id !== exp_word.head_id)
            $display("%0t: head_id expected %0d actual %0d", $time,
                     exp_word.head_id, out_word.head_id);
          if (out_word.status !== exp_word.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_word.status, out_word.status);
          if (out_word.free_blocks !== exp_word.free_blocks)
            $display("%0t: free_blocks expected %0d actual %0d", $time,
                     exp_word.free_blocks, out_word.free_blocks);
          if (out_word !== exp_word) error_count++;
        end
      end
    end
  end

  // The run is stopped if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Picks the id of a block currently in use, or 0 if none is.
  function automatic int unsigned pick_used_id();
    int unsigned start;
    start = $urandom_range(BLOCKS - 1);
    for (int i = 0; i < BLOCKS; i++)
      if (pool_used[(start + i) % BLOCKS]) return (start + i) % BLOCKS + 1;
    return 0;
  endfunction

  // Directed: field extremes, each status and the chain walk corners.
  task automatic test_directed();
    send_request(KIND_ALLOC, 0, 0);            // zero length
    send_request(KIND_ALLOC, 1, 2047);         // one block
    send_request(KIND_ALLOC, 500, 0);          // exactly one block
    send_request(KIND_ALLOC, 501, 0);          // two blocks
    send_request(KIND_ALLOC, 65535, 0);        // largest chain
    send_request(KIND_FREE, 0, 0);             // id zero
    send_request(KIND_FREE, 65535, 1025);      // id above the pool
    send_request(KIND_FREE, 0, 2047);          // all id bits set
    send_request(KIND_FREE, 0, 1);             // free single block
    send_request(KIND_FREE, 0, 1);             // free again: not allocated
    send_request(KIND_FREE, 0, 4);             // free from an inner block
    send_request(KIND_FREE, 0, 3);             // walk meets a free block
    send_request(KIND_FREE, 0, 5);             // head of the large chain
    // Fill the pool and overflow it.
    for (int i = 0; i < 8; i++) send_request(KIND_ALLOC, 65535, 0);
    send_request(KIND_ALLOC, 65535, 0);        // pool full
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_FREE, 0, 1024);          // last block of the pool
    send_request(KIND_ALLOC, 1, 0);
  endtask

  // Random: mostly frees of live chains and mixed-size allocations.
  task automatic test_random(input int unsigned count);
    int unsigned sel, len;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
        send_request(KIND_ALLOC, len, $urandom);
      end else if (sel < 90) begin
        send_request(KIND_FREE, $urandom, pick_used_id());
      end else begin
        send_request(KIND_FREE, $urandom, $urandom);
      end
    end
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input int unsigned count);
    send_gap_pct = gap;
    stall_pct    = stall;
    test_random(count);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    error_count  = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    pool_free    = BLOCKS;
    for (int i = 0; i < BLOCKS; i++) begin
      pool_used[i] = 1'b0;
      pool_next[i] = 0;
      pool_bytes[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    run_phase(0, 0, 250);
    run_phase(84, 0, 150);
    run_phase(0, 84, 150);
    run_phase(30, 30, 150);
    run_phase(0, 0, 150);
    in_valid <= 1'b0;

    while (result_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (error_count == 0 && result_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
